@@ rtl/range_gcd_min_count_tree_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef RANGE_GCD_MIN_COUNT_TREE_CORE_MACROS_SVH
`define RANGE_GCD_MIN_COUNT_TREE_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define RGMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgmc assertion failed");

// Next-cycle implication, off during reset.
`define RGMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgmc assertion failed");

`endif

@@ rtl/rgmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmc_pkg
// Types and constants of the range gcd / min / count segment tree.
// ----------------------------------------------------------------------------
package rgmc_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned ValueBits   = 30;
  localparam int unsigned PosBits     = 11;
  localparam int unsigned NodeBits    = 12;   // 4 * MaxElements nodes
  localparam int unsigned StackBits   = 4;
  localparam int unsigned NodeWidth   = 2 * ValueBits + PosBits;

  localparam logic [ValueBits-1:0] MinIdentity = '1;

  typedef struct packed {
    logic [ValueBits-1:0] mn;
    logic [ValueBits-1:0] g;
    logic [PosBits-1:0]   cnt;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_DESC,
    ST_LD_UP,
    ST_LD_RDL,
    ST_LD_RDR,
    ST_LD_GCD,
    ST_Q_POP,
    ST_Q_RD,
    ST_Q_GCD,
    ST_Q_DONE
  } state_e;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

endpackage

@@ rtl/rgmc_node_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmc_node_ram
// Simple dual-port node store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rgmc_node_ram #(
  parameter int unsigned AddrBits = 12,
  parameter int unsigned Width    = 71
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [2**AddrBits];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rgmc_gcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmc_gcd
// Iterative binary gcd, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rgmc_gcd import rgmc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] a_i,
  input  logic [ValueBits-1:0] b_i,
  output logic                 done_o,
  output logic [ValueBits-1:0] result_o
);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [ValueBits-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic [4:0]           k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    res_d  = res_q;
    if (start_i) begin
      // zero is the identity: finish at once
      if (a_i == '0) begin
        res_d  = b_i;
        done_d = 1'b1;
      end else if (b_i == '0) begin
        res_d  = a_i;
        done_d = 1'b1;
      end else begin
        a_d    = a_i;
        b_d    = b_i;
        k_d    = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (a_q == b_q) begin
        res_d  = a_q << k_q;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 5'd1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = (a_q - b_q) >> 1;
      end else begin
        b_d = (b_q - a_q) >> 1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/range_gcd_min_count_tree_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_gcd_min_count_tree_core
// Segment tree over up to 1024 values giving range min, gcd, min count and not-dividing count.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_stall_o     func, position, value, range
// out      output     out_valid_o / out_stall_i   range_min, range_gcd, counts
// cfg      input      cfg_we_i                    element_count
//
// One word at a time. A load walks down one level per cycle, then for each
// parent level reads both children, runs a gcd and writes the parent.
// A query pops up to ~4*log2(count) nodes; each covering node adds a node
// read plus a gcd. Reset and each element_count write clear 4096 nodes
// with the input stalled. A finished result waits in the output register;
// a query that finishes while it is still held there stalls the input.
// ----------------------------------------------------------------------------
module range_gcd_min_count_tree_core import rgmc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PosBits-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [PosBits-1:0]   position_i,
  input  logic [ValueBits-1:0] value_i,
  input  logic [PosBits-1:0]   range_low_i,
  input  logic [PosBits-1:0]   range_high_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ValueBits-1:0] range_min_o,
  output logic [ValueBits-1:0] range_gcd_o,
  output logic [PosBits-1:0]   min_count_o,
  output logic [PosBits-1:0]   not_dividing_all_o
);

  state_e state_q, state_d;

  logic [PosBits-1:0]   count_q;
  logic [NodeBits-1:0]  clr_q;
  logic [NodeBits-1:0]  v_q;
  logic [PosBits-1:0]   lo_q, hi_q, pos_q, lq_q, rq_q, len_q;
  logic [ValueBits-1:0] val_q;
  node_t                left_q, acc_q;
  logic [ValueBits-1:0] jmin_q;
  logic [PosBits-1:0]   jcnt_q;
  logic [StackBits:0]   sp_q;
  logic [NodeBits-1:0]  stk_v_q  [2**StackBits];
  logic [PosBits-1:0]   stk_lo_q [2**StackBits];
  logic [PosBits-1:0]   stk_hi_q [2**StackBits];
  logic                 out_valid_q;
  logic [ValueBits-1:0] o_min_q, o_gcd_q;
  logic [PosBits-1:0]   o_cnt_q, o_nd_q;

  // node store and gcd hookup
  logic                 mem_we;
  logic [NodeBits-1:0]  mem_waddr, mem_raddr;
  node_t                mem_wdata, mem_rdata;
  logic [NodeWidth-1:0] mem_rbits;
  logic                 gcd_start, gcd_done;
  logic [ValueBits-1:0] gcd_a, gcd_b, gcd_res;

  rgmc_node_ram #(.AddrBits(NodeBits), .Width(NodeWidth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rbits)
  );
  assign mem_rdata = node_t'(mem_rbits);

  rgmc_gcd u_gcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gcd_start),
    .a_i      (gcd_a),
    .b_i      (gcd_b),
    .done_o   (gcd_done),
    .result_o (gcd_res)
  );

  // helper values
  logic                 in_acc, out_free;
  logic [PosBits-1:0]   mid, cfg_clamped, q_lo, q_hi;
  logic [StackBits-1:0] top_idx;
  logic [NodeBits-1:0]  t_v;
  logic [PosBits-1:0]   t_lo, t_hi, t_mid;
  logic                 t_disj, t_cover;
  logic                 rd_lt, rd_gt;
  logic [ValueBits-1:0] rd_min;
  logic [PosBits-1:0]   rd_cnt;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mid      = PosBits'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign top_idx  = StackBits'(sp_q - 1'b1);
  assign t_v      = stk_v_q[top_idx];
  assign t_lo     = stk_lo_q[top_idx];
  assign t_hi     = stk_hi_q[top_idx];
  assign t_mid    = PosBits'(({1'b0, t_lo} + {1'b0, t_hi}) >> 1);
  assign t_disj   = (t_hi < lq_q) || (rq_q < t_lo);
  assign t_cover  = (lq_q <= t_lo) && (t_hi <= rq_q);
  assign q_lo     = (range_low_i == '0) ? PosBits'(1) : range_low_i;
  assign q_hi     = (range_high_i > count_q) ? count_q : range_high_i;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_clamped = PosBits'(1);
    end else if (cfg_wdata_i > PosBits'(MaxElements)) begin
      cfg_clamped = PosBits'(MaxElements);
    end else begin
      cfg_clamped = cfg_wdata_i;
    end
  end

  // min and count merge: left or accumulator against the word just read
  always_comb begin
    node_t a;
    a      = (state_q == ST_Q_RD) ? acc_q : left_q;
    rd_lt  = a.mn < mem_rdata.mn;
    rd_gt  = mem_rdata.mn < a.mn;
    rd_min = rd_gt ? mem_rdata.mn : a.mn;
    if (rd_lt) begin
      rd_cnt = a.cnt;
    end else if (rd_gt) begin
      rd_cnt = mem_rdata.cnt;
    end else begin
      rd_cnt = a.cnt + mem_rdata.cnt;
    end
    gcd_a = a.g;
  end
  assign gcd_b = mem_rdata.g;

  // next state and store / gcd controls
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = v_q;
    mem_wdata = node_t'{mn: jmin_q, g: gcd_res, cnt: jcnt_q};
    mem_raddr = v_q;
    gcd_start = 1'b0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = node_t'{mn: MinIdentity, g: '0, cnt: '0};
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FuncQuery) begin
            state_d = ST_Q_POP;
          end else if (position_i != '0 && position_i <= count_q) begin
            state_d = ST_LD_DESC;
          end
        end
      end
      ST_LD_DESC: begin
        if (lo_q == hi_q) begin
          mem_we    = 1'b1;
          mem_wdata = node_t'{mn: val_q, g: val_q, cnt: PosBits'(1)};
          state_d   = ST_LD_UP;
        end
      end
      ST_LD_UP: begin
        mem_raddr = {v_q[NodeBits-1:1], 1'b0};
        if (v_q == NodeBits'(1)) state_d = ST_IDLE;
        else state_d = ST_LD_RDL;
      end
      ST_LD_RDL: begin
        mem_raddr = {v_q[NodeBits-2:0], 1'b1};
        state_d   = ST_LD_RDR;
      end
      ST_LD_RDR: begin
        gcd_start = 1'b1;
        state_d   = ST_LD_GCD;
      end
      ST_LD_GCD: begin
        if (gcd_done) begin
          mem_we  = 1'b1;
          state_d = ST_LD_UP;
        end
      end
      ST_Q_POP: begin
        mem_raddr = t_v;
        if (sp_q == '0) state_d = ST_Q_DONE;
        else if (!t_disj && t_cover) state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        gcd_start = 1'b1;
        state_d   = ST_Q_GCD;
      end
      ST_Q_GCD: begin
        if (gcd_done) state_d = ST_Q_POP;
      end
      ST_Q_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // a register write restarts the clearing pass
    if (cfg_we_i) state_d = ST_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= PosBits'(1);
      clr_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_clamped;
        clr_q   <= '0;
      end else if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_Q_DONE && out_free) out_valid_q <= 1'b1;
      if (state_q == ST_IDLE && in_acc) begin
        // seed the walk with the root; an empty range pushes nothing
        sp_q <= (q_lo <= q_hi) ? (StackBits + 1)'(1) : '0;
      end else if (state_q == ST_Q_POP && sp_q != '0) begin
        if (t_disj || t_cover) sp_q <= sp_q - 1'b1;
        else sp_q <= sp_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        v_q    <= NodeBits'(1);
        lo_q   <= PosBits'(1);
        hi_q   <= count_q;
        pos_q  <= position_i;
        val_q  <= value_i;
        lq_q   <= q_lo;
        rq_q   <= q_hi;
        len_q  <= (q_lo <= q_hi) ? PosBits'(q_hi - q_lo + 1'b1) : '0;
        acc_q  <= node_t'{mn: MinIdentity, g: '0, cnt: '0};
        stk_v_q[0]  <= NodeBits'(1);
        stk_lo_q[0] <= PosBits'(1);
        stk_hi_q[0] <= count_q;
      end
      ST_LD_DESC: begin
        if (lo_q != hi_q) begin
          if (pos_q <= mid) begin
            v_q  <= {v_q[NodeBits-2:0], 1'b0};
            hi_q <= mid;
          end else begin
            v_q  <= {v_q[NodeBits-2:0], 1'b1};
            lo_q <= mid + 1'b1;
          end
        end
      end
      ST_LD_UP: v_q <= v_q >> 1;
      ST_LD_RDL: left_q <= mem_rdata;
      ST_LD_RDR: begin
        jmin_q <= rd_min;
        jcnt_q <= rd_cnt;
      end
      ST_Q_POP: begin
        if (sp_q != '0 && !t_disj && !t_cover) begin
          // split: left child replaces the top, right child goes above it
          stk_v_q[top_idx]   <= {t_v[NodeBits-2:0], 1'b0};
          stk_hi_q[top_idx]  <= t_mid;
          stk_v_q[sp_q[StackBits-1:0]]  <= {t_v[NodeBits-2:0], 1'b1};
          stk_lo_q[sp_q[StackBits-1:0]] <= t_mid + 1'b1;
          stk_hi_q[sp_q[StackBits-1:0]] <= t_hi;
        end
      end
      ST_Q_RD: begin
        acc_q.mn  <= rd_min;
        acc_q.cnt <= rd_cnt;
      end
      ST_Q_GCD: if (gcd_done) acc_q.g <= gcd_res;
      ST_Q_DONE: begin
        if (out_free) begin
          o_min_q <= acc_q.mn;
          o_gcd_q <= acc_q.g;
          o_cnt_q <= acc_q.cnt;
          if (acc_q.g == acc_q.mn) begin
            o_nd_q <= (acc_q.cnt > len_q) ? '0 : len_q - acc_q.cnt;
          end else begin
            o_nd_q <= len_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign range_min_o        = o_min_q;
  assign range_gcd_o        = o_gcd_q;
  assign min_count_o        = o_cnt_q;
  assign not_dividing_all_o = o_nd_q;

endmodule

@@ rtl/rgmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgmc_checker
// Port-level checks of the segment tree core, bound into the core module.
// ----------------------------------------------------------------------------
`include "range_gcd_min_count_tree_core_macros.svh"

module rgmc_checker import rgmc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 func_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ValueBits-1:0] range_min_o,
  input logic [PosBits-1:0]   min_count_o,
  input logic [PosBits-1:0]   not_dividing_all_o
);

  `RGMC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(range_min_o))
  `RGMC_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && func_i == FuncQuery, in_stall_o)
  `RGMC_ASSERT_NEXT(a_clear_after_cfg, cfg_we_i, in_stall_o)
  `RGMC_ASSERT_IMPL(a_cnt_bound, out_valid_o, min_count_o <= PosBits'(MaxElements))
  `RGMC_ASSERT_IMPL(a_nd_bound, out_valid_o, not_dividing_all_o <= PosBits'(MaxElements))

endmodule

bind range_gcd_min_count_tree_core rgmc_checker u_rgmc_checker (.*);
